@@ sv/flru_pkg.sv @@
// ----------------------------------------------------------------------------
// flru_pkg
// Shared types and constants of the four-way lru cache lookup core.
// ----------------------------------------------------------------------------
package flru_pkg;

	// field widths of the stream beats
	localparam int KIND_W       = 2;
	localparam int ADDR_FIELD_W = 32;
	localparam int OUTCOME_W    = 2;
	localparam int WAY_FIELD_W  = 2;
	localparam int M_TDATA_W    = 8;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 4;

	// parameter defaults
	localparam int MAX_SET_INDEX_BITS_DEF = 10;
	localparam int WAYS_DEF               = 4;
	localparam int ADDR_WIDTH_DEF         = 32;

	// register reset values
	localparam logic                  SPLIT_MODE_RST     = 1'b0;
	localparam logic [CFG_DATA_W-1:0] SET_INDEX_BITS_RST = 4'd10;
	localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST    = 4'd5;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_FETCH = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUTCOME_HIT        = 2'd0,
		OUTCOME_COMPULSORY = 2'd1,
		OUTCOME_REPLACE    = 2'd2,
		OUTCOME_IGNORED    = 2'd3
	} outcome_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SPLIT_MODE     = 2'd0,
		CFG_SET_INDEX_BITS = 2'd1,
		CFG_OFFSET_BITS    = 2'd2
	} cfg_idx_t;

	// what the row update reports for one lookup
	typedef struct packed {
		outcome_t                 outcome;
		logic [WAY_FIELD_W-1:0]   way;
	} lookup_res_t;

endpackage

@@ sv/flru_row_ram.sv @@
// ----------------------------------------------------------------------------
// flru_row_ram
// Simple dual-port set memory, one write and one registered read per cycle.
// A read and a write of the same row in one cycle return the old row.
// ----------------------------------------------------------------------------
module flru_row_ram #(
	parameter int ADDR_W = 11,
	parameter int DATA_W = 140
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/flru_row_update.sv @@
// ----------------------------------------------------------------------------
// flru_row_update
// Tag compare, way choice and exact lru rank update for one set row.
// Row layout from the lowest bit: tags, valid bits, ranks (0 = most recent).
// ----------------------------------------------------------------------------
module flru_row_update #(
	parameter int WAYS  = 4,
	parameter int TAG_W = 32
) (
	input  logic [WAYS*(TAG_W+1+$clog2(WAYS))-1:0] row_in,
	input  logic [TAG_W-1:0]                       tag,
	output logic [WAYS*(TAG_W+1+$clog2(WAYS))-1:0] row_out,
	output flru_pkg::lookup_res_t                  res
);

	localparam int WAY_W    = $clog2(WAYS);
	localparam int VLD_LSB  = WAYS*TAG_W;
	localparam int RANK_LSB = WAYS*(TAG_W+1);

	logic [TAG_W-1:0] tags [WAYS];
	logic [WAY_W-1:0] rank [WAYS];
	logic [WAYS-1:0]  vld;

	logic [TAG_W-1:0] tags_n [WAYS];
	logic [WAY_W-1:0] rank_n [WAYS];
	logic [WAYS-1:0]  vld_n;

	logic             hit_found;
	logic [WAY_W-1:0] hit_way;
	logic             free_found;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] victim;
	logic [WAY_W-1:0] victim_rank;
	logic [WAY_W-1:0] sel;
	logic [WAY_W-1:0] sel_rank;
	logic             was_valid;
	logic [WAY_W+1:0] sel_ext;

	always_comb begin
		vld = row_in[VLD_LSB +: WAYS];
		for (int w = 0; w < WAYS; w++) begin
			tags[w] = row_in[w*TAG_W +: TAG_W];
			rank[w] = row_in[RANK_LSB + w*WAY_W +: WAY_W];
		end
	end

	// lowest matching way, lowest free way, lowest way with the oldest rank
	always_comb begin
		hit_found  = 1'b0;
		hit_way    = '0;
		free_found = 1'b0;
		free_way   = '0;
		for (int w = WAYS-1; w >= 0; w--) begin
			if (vld[w] && tags[w] == tag) begin
				hit_found = 1'b1;
				hit_way   = WAY_W'(w);
			end
			if (!vld[w]) begin
				free_found = 1'b1;
				free_way   = WAY_W'(w);
			end
		end
		victim      = '0;
		victim_rank = rank[0];
		for (int w = 1; w < WAYS; w++) begin
			if (rank[w] > victim_rank) begin
				victim      = WAY_W'(w);
				victim_rank = rank[w];
			end
		end
	end

	always_comb begin
		if (hit_found) begin
			sel         = hit_way;
			was_valid   = 1'b1;
			res.outcome = flru_pkg::OUTCOME_HIT;
		end else if (free_found) begin
			sel         = free_way;
			was_valid   = 1'b0;
			res.outcome = flru_pkg::OUTCOME_COMPULSORY;
		end else begin
			sel         = victim;
			was_valid   = 1'b1;
			res.outcome = flru_pkg::OUTCOME_REPLACE;
		end
		sel_ext = {2'b00, sel};
		res.way = sel_ext[flru_pkg::WAY_FIELD_W-1:0];
	end

	// touched way becomes most recent; valid ways younger than it age by one, all valid ways on a fill
	always_comb begin
		sel_rank = rank[sel];
		vld_n    = vld;
		vld_n[sel] = 1'b1;
		for (int k = 0; k < WAYS; k++) begin
			tags_n[k] = tags[k];
			rank_n[k] = rank[k];
			if (WAY_W'(k) == sel) begin
				tags_n[k] = tag;
				rank_n[k] = '0;
			end else if (vld[k] && (!was_valid || rank[k] < sel_rank)) begin
				rank_n[k] = rank[k] + WAY_W'(1);
			end
		end
	end

	always_comb begin
		row_out = '0;
		row_out[VLD_LSB +: WAYS] = vld_n;
		for (int w = 0; w < WAYS; w++) begin
			row_out[w*TAG_W +: TAG_W]             = tags_n[w];
			row_out[RANK_LSB + w*WAY_W +: WAY_W] = rank_n[w];
		end
	end

endmodule

@@ sv/four_way_lru_cache_lookup_core.sv @@
// ----------------------------------------------------------------------------
// four_way_lru_cache_lookup_core
// Tag and exact lru replacement logic of a set-associative cache.
// ----------------------------------------------------------------------------
// Each beat on the slave side is one access (kind in s_tuser, byte address in
// s_tdata); each beat on the master side is its outcome, way and the half that
// served it. All sets live in one row memory (one row per set: tags, valid
// bits, ranks) with a registered read. An access reads its row at the edge it
// is accepted and writes the updated row as it moves to the output register, so
// the block sustains one access per cycle unless the output stalls; an access
// to the row written in the same cycle takes the written row from a bypass
// register. After reset the block sweeps the memory clearing the valid bits,
// one row per cycle, over 2**(MAX_SET_INDEX_BITS+1) rows (2048 at the default),
// with s_tready low; configuration writes are taken throughout. The user must
// write configuration only while no access is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module four_way_lru_cache_lookup_core #(
	parameter int MAX_SET_INDEX_BITS = flru_pkg::MAX_SET_INDEX_BITS_DEF,
	parameter int WAYS               = flru_pkg::WAYS_DEF,
	parameter int ADDR_WIDTH         = flru_pkg::ADDR_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [flru_pkg::ADDR_FIELD_W-1:0]   s_tdata,   // [31:0] address
	input  logic [flru_pkg::KIND_W-1:0]         s_tuser,   // [1:0] kind

	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [flru_pkg::M_TDATA_W-1:0]      m_tdata,   // [1:0] outcome, [3:2] way
	output logic                                m_tuser,   // [0] instruction_side

	input  logic                                cfg_we,
	input  logic [flru_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [flru_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int TAG_W   = (ADDR_WIDTH < flru_pkg::ADDR_FIELD_W) ?
	                         ADDR_WIDTH : flru_pkg::ADDR_FIELD_W;
	localparam int WAY_W   = $clog2(WAYS);
	localparam int ROW_W   = WAYS*(TAG_W+1+WAY_W);
	localparam int ROW_AW  = MAX_SET_INDEX_BITS + 1;
	localparam int SHIFT_W = $clog2(MAX_SET_INDEX_BITS + 2**flru_pkg::CFG_DATA_W);
	localparam int PAD_W   = flru_pkg::M_TDATA_W - flru_pkg::OUTCOME_W -
	                         flru_pkg::WAY_FIELD_W;

	// configuration registers
	logic                            split_q;
	logic [flru_pkg::CFG_DATA_W-1:0] set_bits_q;
	logic [flru_pkg::CFG_DATA_W-1:0] off_bits_q;

	// valid clearing sweep
	logic              clearing_q;
	logic [ROW_AW-1:0] clr_idx_q;

	// stage 1: row read in flight
	logic              valid_s1;
	logic              ignore_s1;
	logic              half_s1;
	logic [ROW_AW-1:0] row_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              fwd_s1;
	logic [ROW_W-1:0]  fwd_row_q;

	// output register
	logic                               m_tvalid_q;
	flru_pkg::outcome_t                 out_outcome_q;
	logic [flru_pkg::WAY_FIELD_W-1:0]   out_way_q;
	logic                               out_side_q;

	logic                            in_acc;
	logic                            s1_go;
	logic                            s1_wr;
	flru_pkg::kind_t                 in_kind;
	logic [TAG_W-1:0]                addr_eff;
	logic [flru_pkg::CFG_DATA_W-1:0] s_sat;
	logic [TAG_W-1:0]                addr_sh;
	logic [MAX_SET_INDEX_BITS-1:0]   set_mask;
	logic [MAX_SET_INDEX_BITS-1:0]   set_in;
	logic                            half_in;
	logic [ROW_AW-1:0]               row_in;
	logic [SHIFT_W-1:0]              tag_sh;
	logic [TAG_W-1:0]                tag_in;

	logic                  mem_wr_en;
	logic [ROW_AW-1:0]     mem_wr_addr;
	logic [ROW_W-1:0]      mem_wr_data;
	logic [ROW_W-1:0]      rd_row;
	logic [ROW_W-1:0]      row_cur;
	logic [ROW_W-1:0]      row_new;
	flru_pkg::lookup_res_t res;

	// ---------------------------------------------------------------- decode
	always_comb begin
		in_kind  = flru_pkg::kind_t'(s_tuser);
		addr_eff = s_tdata[TAG_W-1:0];
		s_sat    = (set_bits_q > flru_pkg::CFG_DATA_W'(MAX_SET_INDEX_BITS)) ?
		           flru_pkg::CFG_DATA_W'(MAX_SET_INDEX_BITS) : set_bits_q;
		addr_sh  = addr_eff >> off_bits_q;
		set_mask = ~({MAX_SET_INDEX_BITS{1'b1}} << s_sat);
		set_in   = addr_sh[MAX_SET_INDEX_BITS-1:0] & set_mask;
		half_in  = split_q && (in_kind == flru_pkg::KIND_FETCH);
		row_in   = {half_in, set_in};
		tag_sh   = SHIFT_W'(s_sat) + SHIFT_W'(off_bits_q);
		tag_in   = addr_eff >> tag_sh;
	end

	assign s1_go    = valid_s1 && (!m_tvalid_q || m_tready);
	assign s1_wr    = s1_go && !ignore_s1;
	assign s_tready = !clearing_q && (!valid_s1 || s1_go);
	assign in_acc   = s_tvalid && s_tready;

	// --------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q    <= flru_pkg::SPLIT_MODE_RST;
			set_bits_q <= flru_pkg::SET_INDEX_BITS_RST;
			off_bits_q <= flru_pkg::OFFSET_BITS_RST;
		end else if (cfg_we) begin
			case (flru_pkg::cfg_idx_t'(cfg_index))
				flru_pkg::CFG_SPLIT_MODE: begin
					split_q <= cfg_wdata[0];
				end
				flru_pkg::CFG_SET_INDEX_BITS: begin
					set_bits_q <= cfg_wdata;
				end
				flru_pkg::CFG_OFFSET_BITS: begin
					off_bits_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// --------------------------------------------------------- clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + ROW_AW'(1);
			if (clr_idx_q == {ROW_AW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- memory
	assign mem_wr_en   = clearing_q || s1_wr;
	assign mem_wr_addr = clearing_q ? clr_idx_q : row_s1;
	assign mem_wr_data = clearing_q ? '0 : row_new;

	flru_row_ram #(
		.ADDR_W (ROW_AW),
		.DATA_W (ROW_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (row_in),
		.rd_data (rd_row),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ignore_s1 <= (in_kind == flru_pkg::KIND_OTHER);
			half_s1   <= half_in;
			row_s1    <= row_in;
			tag_s1    <= tag_in;
			// the memory returns the old row when it is written at the read edge
			fwd_s1    <= s1_wr && (row_s1 == row_in);
		end
		if (s1_wr) begin
			fwd_row_q <= row_new;
		end
	end

	assign row_cur = fwd_s1 ? fwd_row_q : rd_row;

	flru_row_update #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W)
	) u_update (
		.row_in  (row_cur),
		.tag     (tag_s1),
		.row_out (row_new),
		.res     (res)
	);

	// -------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			if (ignore_s1) begin
				out_outcome_q <= flru_pkg::OUTCOME_IGNORED;
				out_way_q     <= '0;
				out_side_q    <= 1'b0;
			end else begin
				out_outcome_q <= res.outcome;
				out_way_q     <= res.way;
				out_side_q    <= half_s1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_way_q, out_outcome_q};
	assign m_tuser  = out_side_q;

`ifndef SYNTHESIS
	// nothing moves through the pipe while the valid bits are being cleared
	a_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (!valid_s1 && !m_tvalid))
		else $error("access in flight during clearing sweep");

	// an ignored access reports way 0 on the data half
	a_ignored_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == flru_pkg::OUTCOME_IGNORED) |->
		(m_tdata[3:2] == 2'd0 && !m_tuser))
		else $error("ignored beat carries way or side");

	// the bypass is armed only when the row was written at the read edge
	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !(s1_wr && row_s1 == row_in)) |=> !fwd_s1)
		else $error("bypass armed without a same-row write");
`endif

endmodule

@@ tb/sv/tb_four_way_lru_cache_lookup_core.sv @@
// ----------------------------------------------------------------------------
// tb_four_way_lru_cache_lookup_core
// Self-checking testbench for the four-way lru cache lookup core.
// ----------------------------------------------------------------------------
// A short table of directed accesses and settings changes runs first. Random
// phases follow, each under its own split, set index and offset setting. Most
// accesses come from a small pool of blocks that share a few sets, so hits,
// fills and lru replacements all show up. A cycle-free tag/valid/rank mirror
// of the cache predicts the outcome beats of untyped accesses. Both stream sides
// stall in random bursts, except in the quiet phases and the last phase.
// ----------------------------------------------------------------------------
module tb_four_way_lru_cache_lookup_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SET_MAX       = flru_pkg::MAX_SET_INDEX_BITS_DEF;
	localparam int SETS_PER_HALF = 1 << SET_MAX;
	localparam int NWAYS         = flru_pkg::WAYS_DEF;
	localparam int ENTRIES       = 2 * SETS_PER_HALF * NWAYS;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 153;
	localparam int POOL          = 12;
	localparam int DIRECTED_ROWS = 26;

	typedef struct packed {
		flru_pkg::outcome_t outcome;
		logic [1:0]         way;
		logic               side;
	} outcome_beat_t;

	typedef enum bit {ROW_ACCESS, ROW_SETTINGS} row_op_t;

	typedef struct {
		row_op_t            op;
		flru_pkg::kind_t    kind;
		logic [31:0]        addr;
		bit                 split;
		bit [3:0]           sib;
		bit [3:0]           off;
		bit                 typed;
		flru_pkg::outcome_t exp_outcome;
		logic [1:0]         exp_way;
		logic               exp_side;
	} stim_row_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [flru_pkg::ADDR_FIELD_W-1:0] s_tdata  = '0;
	logic [flru_pkg::KIND_W-1:0]      s_tuser   = '0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b1;
	logic [flru_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                             m_tuser;
	logic                             cfg_we    = 1'b0;
	logic [flru_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [flru_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	// mirror of the cache state and settings
	logic [31:0] tag_mem [ENTRIES];
	bit          valid_mem [ENTRIES];
	bit [1:0]    rank_mem [ENTRIES];
	bit          cur_split;
	bit [3:0]    cur_sib;
	bit [3:0]    cur_off;

	outcome_beat_t pending_outcomes [$];
	int            fail_count = 0;
	bit            idle_on    = 1'b0;
	int            stall_left = 0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_ACCESS,   flru_pkg::KIND_OTHER, 32'hFFFF_FFFF, 0, 0, 0,
			1, flru_pkg::OUTCOME_IGNORED,    2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0000_0000, 0, 0, 0,
			1, flru_pkg::OUTCOME_COMPULSORY, 2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0000_0000, 0, 0, 0,
			1, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_WRITE, 32'h0000_001F, 0, 0, 0,
			1, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_FETCH, 32'h0000_0004, 0, 0, 0,
			1, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0000_8000, 0, 0, 0,
			1, flru_pkg::OUTCOME_COMPULSORY, 2'd1, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_WRITE, 32'h0001_0000, 0, 0, 0,
			1, flru_pkg::OUTCOME_COMPULSORY, 2'd2, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_FETCH, 32'h0001_8000, 0, 0, 0,
			1, flru_pkg::OUTCOME_COMPULSORY, 2'd3, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0002_0000, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0000_8000, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_WRITE, 32'hFFFF_FFFF, 0, 0, 0,
			1, flru_pkg::OUTCOME_COMPULSORY, 2'd0, 1'b0},
		'{ROW_SETTINGS, flru_pkg::KIND_READ,  32'h0000_0000, 1, 10, 5,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_FETCH, 32'h0000_0000, 0, 0, 0,
			1, flru_pkg::OUTCOME_COMPULSORY, 2'd0, 1'b1},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0000_0000, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_FETCH, 32'hFFFF_FFE0, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_SETTINGS, flru_pkg::KIND_READ,  32'h0000_0000, 1, 15, 15,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h7FFF_8000, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_FETCH, 32'h8000_0000, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_SETTINGS, flru_pkg::KIND_READ,  32'h0000_0000, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0000_0001, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_WRITE, 32'h0000_0002, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0000_0003, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_FETCH, 32'h0000_0004, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_READ,  32'h0000_0005, 0, 0, 0,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_SETTINGS, flru_pkg::KIND_READ,  32'h0000_0000, 0, 10, 12,
			0, flru_pkg::OUTCOME_HIT,        2'd0, 1'b0},
		'{ROW_ACCESS,   flru_pkg::KIND_OTHER, 32'h1234_5678, 0, 0, 0,
			1, flru_pkg::OUTCOME_IGNORED,    2'd0, 1'b0}
	};

	four_way_lru_cache_lookup_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [31:0] address
		.s_tuser   (s_tuser),   // [1:0] kind
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [1:0] outcome, [3:2] way
		.m_tuser   (m_tuser),   // [0] instruction_side
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// way w becomes most recent; valid ranks newer than its old rank age by one, all valid ones on a fill
	function automatic void mark_recent(int unsigned base, int unsigned w, bit was_valid);
		bit [1:0] old_rank;
		old_rank = rank_mem[base + w];
		for (int k = 0; k < NWAYS; k++) begin
			if (k != w && valid_mem[base + k] && (!was_valid || rank_mem[base + k] < old_rank))
				rank_mem[base + k] = rank_mem[base + k] + 2'd1;
		end
		rank_mem[base + w] = 2'd0;
	endfunction

	function automatic outcome_beat_t lookup_outcome(flru_pkg::kind_t kind,
		logic [31:0] addr);
		int unsigned    s, b, half, set_idx, base, victim, hit_way, free_way;
		longint unsigned a, tag_v;
		outcome_beat_t  r;
		r.outcome = flru_pkg::OUTCOME_IGNORED;
		r.way = 2'd0;
		r.side = 1'b0;
		if (kind == flru_pkg::KIND_OTHER)
			return r;
		s = (cur_sib > SET_MAX) ? SET_MAX : cur_sib;
		b = cur_off;
		a = addr;
		half = (cur_split && kind == flru_pkg::KIND_FETCH) ? 1 : 0;
		set_idx = int'((a >> b) & ((64'd1 << s) - 64'd1));
		tag_v = a >> (s + b);
		base = (half * SETS_PER_HALF + set_idx) * NWAYS;
		r.side = half[0];
		hit_way = NWAYS;
		free_way = NWAYS;
		for (int w = 0; w < NWAYS; w++) begin
			if (valid_mem[base + w] && tag_mem[base + w] == tag_v[31:0] && hit_way == NWAYS)
				hit_way = w;
			if (!valid_mem[base + w] && free_way == NWAYS)
				free_way = w;
		end
		if (hit_way != NWAYS) begin
			mark_recent(base, hit_way, 1'b1);
			r.outcome = flru_pkg::OUTCOME_HIT;
			r.way = hit_way[1:0];
		end else if (free_way != NWAYS) begin
			tag_mem[base + free_way] = tag_v[31:0];
			valid_mem[base + free_way] = 1'b1;
			mark_recent(base, free_way, 1'b0);
			r.outcome = flru_pkg::OUTCOME_COMPULSORY;
			r.way = free_way[1:0];
		end else begin
			victim = 0;
			for (int w = 0; w < NWAYS; w++) begin
				if (rank_mem[base + w] > rank_mem[base + victim])
					victim = w;
			end
			tag_mem[base + victim] = tag_v[31:0];
			mark_recent(base, victim, 1'b1);
			r.outcome = flru_pkg::OUTCOME_REPLACE;
			r.way = victim[1:0];
		end
		return r;
	endfunction

	// settings change only with nothing in flight
	task automatic write_settings(bit split, bit [3:0] sib, bit [3:0] off);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= flru_pkg::CFG_SPLIT_MODE;
		cfg_wdata <= {3'b000, split};
		@(posedge clk);
		cfg_index <= flru_pkg::CFG_SET_INDEX_BITS;
		cfg_wdata <= sib;
		@(posedge clk);
		cfg_index <= flru_pkg::CFG_OFFSET_BITS;
		cfg_wdata <= off;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_split = split;
		cur_sib = sib;
		cur_off = off;
	endtask

	task automatic send_access(flru_pkg::kind_t kind, logic [31:0] addr, bit typed,
		outcome_beat_t typed_exp);
		outcome_beat_t predicted;
		s_tvalid <= 1'b1;
		s_tdata <= addr;
		s_tuser <= kind;
		// ready seen at the falling edge holds for the next rising edge
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		predicted = lookup_outcome(kind, addr);
		pending_outcomes.push_back(typed ? typed_exp : predicted);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (!idle_on)
			stall_left = 0;
		else if (stall_left == 0 && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 16);
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// outcome beat check, sampled at the falling edge before the accepting edge
	always @(negedge clk) begin
		outcome_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				$error("outcome beat with nothing pending: tdata %0h tuser %0d", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (m_tdata[1:0] !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, m_tdata[1:0]);
					fail_count++;
				end
				if (m_tdata[3:2] !== want.way) begin
					$error("way: expected %0d, got %0d", want.way, m_tdata[3:2]);
					fail_count++;
				end
				if (m_tuser !== want.side) begin
					$error("instruction_side: expected %0d, got %0d", want.side, m_tuser);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		outcome_beat_t   row_exp;
		longint unsigned pool_addr [POOL];
		longint unsigned set_pick [3];
		longint unsigned tv, off_mask;
		int unsigned     eff_sib, n_sets, tag_base, r;
		flru_pkg::kind_t k;
		logic [31:0]     addr32;

		for (int i = 0; i < ENTRIES; i++) begin
			valid_mem[i] = 1'b0;
			rank_mem[i] = 2'd0;
			tag_mem[i] = '0;
		end
		cur_split = flru_pkg::SPLIT_MODE_RST;
		cur_sib = flru_pkg::SET_INDEX_BITS_RST;
		cur_off = flru_pkg::OFFSET_BITS_RST;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		idle_on = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_SETTINGS) begin
				write_settings(directed_rows[i].split, directed_rows[i].sib, directed_rows[i].off);
			end else begin
				row_exp.outcome = directed_rows[i].exp_outcome;
				row_exp.way = directed_rows[i].exp_way;
				row_exp.side = directed_rows[i].exp_side;
				send_access(directed_rows[i].kind, directed_rows[i].addr,
					directed_rows[i].typed, row_exp);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					write_settings(1'b1, 4'd0, 4'd0);
				end
				1: begin
					write_settings(1'b0, 4'd15, 4'd15);
				end
				2: begin
					write_settings(1'b1, 4'd10, 4'd12);
				end
				3: begin
					write_settings(1'b0, 4'd1, 4'd2);
				end
				default: begin
					write_settings(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
						4'($urandom_range(0, 15)));
				end
			endcase
			idle_on = (p != PHASES - 1) && (p % 4 != 2);
			eff_sib = (cur_sib > SET_MAX) ? SET_MAX : cur_sib;
			off_mask = (64'd1 << cur_off) - 64'd1;

			// a few sets, a handful of tags each: enough to overflow four ways
			n_sets = $urandom_range(1, 3);
			tag_base = $urandom;
			for (int i = 0; i < 3; i++)
				set_pick[i] = 64'($urandom) & ((64'd1 << eff_sib) - 64'd1);
			for (int i = 0; i < POOL; i++) begin
				tv = 64'(tag_base) + 64'($urandom_range(0, 6));
				pool_addr[i] = (tv << (eff_sib + cur_off))
					| (set_pick[$urandom_range(0, n_sets - 1)] << cur_off);
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					k = flru_pkg::KIND_OTHER;
					addr32 = $urandom;
				end else if (r < 18) begin
					k = flru_pkg::kind_t'($urandom_range(0, 2));
					addr32 = $urandom;
				end else begin
					k = flru_pkg::kind_t'($urandom_range(0, 2));
					tv = pool_addr[$urandom_range(0, POOL - 1)] | (64'($urandom) & off_mask);
					addr32 = tv[31:0];
				end
				send_access(k, addr32, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
sv/flru_pkg.sv
sv/flru_row_ram.sv
sv/flru_row_update.sv
sv/four_way_lru_cache_lookup_core.sv
tb/sv/tb_four_way_lru_cache_lookup_core.sv
